// ===== design/first_fit_bin_packer_unit_defines.svh =====
// Assertion macros shared by the checker of the first-fit bin packer.
`ifndef FIRST_FIT_BIN_PACKER_UNIT_DEFINES_SVH
`define FIRST_FIT_BIN_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ffbp_pkg.sv =====
`default_nettype none

package ffbp_pkg;

    // Width of sizes, capacity and bin fills.
    localparam int SIZE_W = 16;
    // Width of a fill plus an item size.
    localparam int SUM_W  = SIZE_W + 1;
    // Widths of the result fields.
    localparam int IDX_W  = 6;
    localparam int USED_W = 7;

    // Reset value of the capacity register.
    localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(1000);

    // Command codes carried in tuser.
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    // Result item, packed so that bin_index sits in the lowest bits.
    typedef struct packed {
        logic [USED_W-1:0] bins_used;
        logic              no_room;
        logic              oversize;
        logic              opened_new_bin;
        logic [IDX_W-1:0]  bin_index;
    } res_t;

endpackage

`default_nettype wire

// ===== design/ffbp_fill_ram.sv =====
`default_nettype none

module ffbp_fill_ram
    import ffbp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [SIZE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [SIZE_W-1:0] rd_data
);

    logic [SIZE_W-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/first_fit_bin_packer_unit.sv =====
// First-fit bin packer.
// Input channel s_*: one transfer carries a command in s_tuser (place or
// clear) and an item size in s_tdata. A place puts the item into the lowest
// open bin whose fill plus the size stays within the capacity, or opens a
// new bin; when all MAX_BINS bins are open and none fits, the item is
// refused. A clear closes every bin. Each input transfer gives exactly one
// result transfer on m_* with the bin index, the flags and the open count.
// The capacity is to be written through cfg_wr_en/cfg_wr_data by the user
// only while idle; the block itself does not enforce this. The bin fills
// live in a one-port-read memory that is read one bin per cycle from bin 0
// upward. The next input is taken once the result has moved to the
// output register. Reset (aresetn low, synchronous) closes all bins, sets
// the capacity to 1000 and clears the output valid flag; the fill memory
// is not cleared. A stalled receiver holds the result in the output
// register; one further result is kept pending and input stops until the
// register frees up.
`default_nettype none

module first_fit_bin_packer_unit
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS  = 64,
    parameter int SIZE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Capacity register write.
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // bin_capacity
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // item_size[15:0]
    input  wire logic [0:0]  s_tuser,       // command[0]
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata        // bin_index[5:0], opened_new_bin[6],
                                            // oversize[7], no_room[8],
                                            // bins_used[15:9]
);

    localparam int AW   = $clog2(MAX_BINS);
    localparam int CW   = $clog2(MAX_BINS + 1);
    localparam int SZ_W = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
    localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((64'(1) << SZ_W) - 64'(1));
    localparam logic [CW-1:0]     MAX_CNT   = CW'(MAX_BINS);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] cap_reg;
    logic [CW-1:0]     bins_open_reg, bins_open_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              over_reg, over_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic [AW-1:0]     rd_idx_reg;
    logic              rd_valid_reg;
    res_t              res_reg, res_next;
    res_t              out_reg;
    logic              m_tvalid_reg;

    logic              in_xfer;
    logic [SIZE_W-1:0] in_size;
    logic              in_over;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [SIZE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [SIZE_W-1:0] rd_data;
    logic [SUM_W-1:0]  fit_sum;
    logic              fits;
    logic              last_rd;
    logic              bins_full;
    logic              out_load;

    // Bin fill memory.
    ffbp_fill_ram #(
        .DEPTH (MAX_BINS),
        .AW    (AW)
    ) u_fill_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake and the fit test on the bin just read.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign in_size   = s_tdata & SIZE_MASK;
    assign in_over   = (in_size > cap_reg);
    assign fit_sum   = {1'b0, rd_data} + {1'b0, size_reg};
    assign fits      = (fit_sum <= {1'b0, cap_reg});
    assign last_rd   = ((CW'(rd_idx_reg) + CW'(1)) == bins_open_reg);
    assign bins_full = (bins_open_reg == MAX_CNT);

    // Controller: scan, read-modify-write of one fill, result capture.
    always_comb begin
        state_next     = state_reg;
        bins_open_next = bins_open_reg;
        size_next      = size_reg;
        over_next      = over_reg;
        issue_next     = issue_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = bins_open_reg[AW-1:0];
        wr_data        = size_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[AW-1:0];
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    size_next = in_size;
                    over_next = in_over;
                    if (s_tuser[0] == CMD_CLEAR) begin
                        bins_open_next = '0;
                        res_next       = '0;
                        state_next     = ST_HOLD;
                    end else if (bins_open_reg == '0) begin
                        // Empty run: the item opens bin 0 straight away.
                        wr_en                   = 1'b1;
                        wr_addr                 = '0;
                        wr_data                 = in_size;
                        bins_open_next          = CW'(1);
                        res_next.bin_index      = '0;
                        res_next.opened_new_bin = 1'b1;
                        res_next.oversize       = in_over;
                        res_next.no_room        = 1'b0;
                        res_next.bins_used      = USED_W'(1);
                        state_next              = ST_HOLD;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        issue_next = CW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_valid_reg && fits) begin
                    // First bin with room takes the item.
                    wr_en                   = 1'b1;
                    wr_addr                 = rd_idx_reg;
                    wr_data                 = fit_sum[SIZE_W-1:0];
                    res_next.bin_index      = IDX_W'(rd_idx_reg);
                    res_next.opened_new_bin = 1'b0;
                    res_next.oversize       = over_reg;
                    res_next.no_room        = 1'b0;
                    res_next.bins_used      = USED_W'(bins_open_reg);
                    state_next              = ST_HOLD;
                end else if (rd_valid_reg && last_rd) begin
                    res_next.oversize = over_reg;
                    if (bins_full) begin
                        // Every bin open and none fits: refuse the item.
                        res_next.bin_index      = '0;
                        res_next.opened_new_bin = 1'b0;
                        res_next.no_room        = 1'b1;
                        res_next.bins_used      = USED_W'(bins_open_reg);
                    end else begin
                        wr_en                   = 1'b1;
                        bins_open_next          = bins_open_reg + CW'(1);
                        res_next.bin_index      = IDX_W'(bins_open_reg);
                        res_next.opened_new_bin = 1'b1;
                        res_next.no_room        = 1'b0;
                        res_next.bins_used      = USED_W'(bins_open_next);
                    end
                    state_next = ST_HOLD;
                end else if (issue_reg < bins_open_reg) begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
            end
            ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            bins_open_reg <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bins_open_reg <= bins_open_next;
            rd_valid_reg  <= rd_en;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        over_reg   <= over_next;
        issue_reg  <= issue_next;
        res_reg    <= res_next;
        rd_idx_reg <= rd_addr;
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

// ===== design/ffbp_checker.sv =====
`default_nettype none
`include "first_fit_bin_packer_unit_defines.svh"

module ffbp_checker
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS = 64
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    res_t res;
    assign res = m_tdata;

    // A held result keeps its contents.
    `FFBP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // One item at a time: input closes after each transfer.
    `FFBP_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken on consecutive cycles")

    // A refused item opens nothing and reports bin 0.
    `FFBP_ASSERT_NOW(a_refused, aclk, aresetn, m_tvalid && res.no_room, !res.opened_new_bin && (res.bin_index == '0), "refused item placed")

    // Opening a bin leaves at least one bin open, never beyond the limit.
    `FFBP_ASSERT_NOW(a_opened, aclk, aresetn, m_tvalid && res.opened_new_bin, (res.bins_used != '0) && (int'(res.bins_used) <= MAX_BINS), "open count wrong")

endmodule

bind first_fit_bin_packer_unit ffbp_checker #(
    .MAX_BINS (MAX_BINS)
) u_ffbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
